>>> rtl/bldc_six_step_sensorless_commutator_top_assert.svh
// Assertion macros for the six-step commutator
`ifndef BLDC_SIX_STEP_SENSORLESS_COMMUTATOR_TOP_ASSERT_SVH
`define BLDC_SIX_STEP_SENSORLESS_COMMUTATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BSSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bssc_pkg.sv
// Shared types, codes and constants for the six-step commutator
package bssc_pkg;

    localparam int ADC_BITS = 10;
    localparam int SUM_W    = ADC_BITS + 2;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE      = 3'd4;

    localparam logic [15:0] START_PERIOD_RST = 16'd400;
    localparam logic [15:0] RAMP_STEP_RST    = 16'd40;
    localparam logic [15:0] MIN_PERIOD_RST   = 16'd80;
    localparam logic [7:0]  CROSS_LIMIT_RST  = 8'd10;
    localparam logic [15:0] PERIOD_RST       = 16'd10000;

    localparam logic [2:0] STEP_LAST = 3'd5;

    localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] CNT_MIN = 16'sh8000;

    localparam logic [1:0] DRV_OFF  = 2'd0;
    localparam logic [1:0] DRV_HIGH = 2'd1;
    localparam logic [1:0] DRV_LOW  = 2'd2;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_TRANS   = 2'd2,
        MODE_CLOSED  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
    } drive_set_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ADC_BITS-1:0] volt_a;
        logic [ADC_BITS-1:0] volt_b;
        logic [ADC_BITS-1:0] volt_c;
    } item_t;

    typedef struct packed {
        logic [15:0] start_period;
        logic [15:0] ramp_step;
        logic [15:0] min_period;
        logic [7:0]  crossing_limit;
        logic        reverse_direction;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  step;
        drive_set_t  drive;
        logic [15:0] period;
        mode_t       mode;
        logic        commutated;
    } result_t;

    function automatic drive_set_t drive_lookup(input logic [2:0] step, input mode_t mode);
        drive_set_t d;
        d = '{a: DRV_OFF, b: DRV_OFF, c: DRV_OFF};
        if (mode != MODE_STOPPED)
        begin
            case (step)
                3'd0: d = '{a: DRV_HIGH, b: DRV_LOW,  c: DRV_OFF};
                3'd1: d = '{a: DRV_HIGH, b: DRV_OFF,  c: DRV_LOW};
                3'd2: d = '{a: DRV_OFF,  b: DRV_HIGH, c: DRV_LOW};
                3'd3: d = '{a: DRV_LOW,  b: DRV_HIGH, c: DRV_OFF};
                3'd4: d = '{a: DRV_LOW,  b: DRV_OFF,  c: DRV_HIGH};
                3'd5: d = '{a: DRV_OFF,  b: DRV_LOW,  c: DRV_HIGH};
                default: d = '{a: DRV_OFF, b: DRV_OFF, c: DRV_OFF};
            endcase
        end
        return d;
    endfunction

endpackage

>>> rtl/bssc_cfg_regs.sv
// Configuration register file for the six-step commutator
module bssc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bssc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output bssc_pkg::cfg_t                 cfg
);

    bssc_pkg::cfg_t cfg_reg;
    bssc_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index)
                bssc_pkg::REG_START_PERIOD: cfg_next.start_period      = cfg_data;
                bssc_pkg::REG_RAMP_STEP:    cfg_next.ramp_step         = cfg_data;
                bssc_pkg::REG_MIN_PERIOD:   cfg_next.min_period        = cfg_data;
                bssc_pkg::REG_CROSS_LIMIT:  cfg_next.crossing_limit    = cfg_data[7:0];
                bssc_pkg::REG_REVERSE:      cfg_next.reverse_direction = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_period      <= bssc_pkg::START_PERIOD_RST;
            cfg_reg.ramp_step         <= bssc_pkg::RAMP_STEP_RST;
            cfg_reg.min_period        <= bssc_pkg::MIN_PERIOD_RST;
            cfg_reg.crossing_limit    <= bssc_pkg::CROSS_LIMIT_RST;
            cfg_reg.reverse_direction <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/bssc_commutate.sv
// Commutation state and per-item next-state logic
`include "bldc_six_step_sensorless_commutator_top_assert.svh"

module bssc_commutate (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  bssc_pkg::item_t   item,
    input  bssc_pkg::cfg_t    cfg,
    output bssc_pkg::result_t result
);

    logic [2:0]            step_reg;
    logic [2:0]            step_next;
    bssc_pkg::mode_t       mode_reg;
    bssc_pkg::mode_t       mode_next;
    logic [15:0]           period_reg;
    logic [15:0]           period_next;
    logic signed [15:0]    agree_reg;
    logic signed [15:0]    agree_next;
    logic                  did;

    logic [2:0]                  step_adv;
    logic [bssc_pkg::SUM_W-1:0]  sum;
    logic [bssc_pkg::SUM_W-1:0]  tri_a;
    logic [bssc_pkg::SUM_W-1:0]  tri_b;
    logic [bssc_pkg::SUM_W-1:0]  tri_c;
    logic                        agree;
    logic signed [15:0]          agree_step;
    logic signed [15:0]          limit_ext;

    always_comb
    begin
        if (cfg.reverse_direction)
        begin
            step_adv = (step_reg == 3'd0 || step_reg > bssc_pkg::STEP_LAST) ?
                       bssc_pkg::STEP_LAST : step_reg - 3'd1;
        end
        else
        begin
            step_adv = (step_reg >= bssc_pkg::STEP_LAST) ? 3'd0 : step_reg + 3'd1;
        end
    end

    assign sum   = bssc_pkg::SUM_W'(item.volt_a) + bssc_pkg::SUM_W'(item.volt_b)
                 + bssc_pkg::SUM_W'(item.volt_c);
    assign tri_a = {1'b0, item.volt_a, 1'b0} + bssc_pkg::SUM_W'(item.volt_a);
    assign tri_b = {1'b0, item.volt_b, 1'b0} + bssc_pkg::SUM_W'(item.volt_b);
    assign tri_c = {1'b0, item.volt_c, 1'b0} + bssc_pkg::SUM_W'(item.volt_c);

    always_comb
    begin
        case (step_reg)
            3'd0:    agree = tri_c < sum;
            3'd1:    agree = tri_b > sum;
            3'd2:    agree = tri_a < sum;
            3'd3:    agree = tri_c > sum;
            3'd4:    agree = tri_b < sum;
            3'd5:    agree = tri_a > sum;
            default: agree = 1'b0;
        endcase
    end

    always_comb
    begin
        if (agree)
        begin
            agree_step = (agree_reg == bssc_pkg::CNT_MAX) ? agree_reg : agree_reg + 16'sd1;
        end
        else
        begin
            agree_step = (agree_reg == bssc_pkg::CNT_MIN) ? agree_reg : agree_reg - 16'sd1;
        end
    end

    assign limit_ext = $signed({8'd0, cfg.crossing_limit});

    // next state
    always_comb
    begin
        step_next   = step_reg;
        mode_next   = mode_reg;
        period_next = period_reg;
        agree_next  = agree_reg;
        did         = 1'b0;
        case (item.opcode)
            bssc_pkg::OP_TICK:
            begin
                if (mode_reg == bssc_pkg::MODE_OPEN)
                begin
                    if (period_reg > cfg.min_period)
                    begin
                        period_next = (period_reg > cfg.ramp_step) ?
                                      period_reg - cfg.ramp_step : 16'd0;
                    end
                    else
                    begin
                        mode_next = bssc_pkg::MODE_TRANS;
                    end
                    step_next = step_adv;
                    did       = 1'b1;
                end
                else if (mode_reg == bssc_pkg::MODE_TRANS)
                begin
                    step_next = step_adv;
                    did       = 1'b1;
                end
            end
            bssc_pkg::OP_SAMPLE:
            begin
                if (mode_reg == bssc_pkg::MODE_TRANS || mode_reg == bssc_pkg::MODE_CLOSED)
                begin
                    agree_next = agree_step;
                    if (agree_step > limit_ext)
                    begin
                        agree_next = 16'sd0;
                        mode_next  = bssc_pkg::MODE_CLOSED;
                        step_next  = step_adv;
                        did        = 1'b1;
                    end
                end
            end
            bssc_pkg::OP_START:
            begin
                period_next = cfg.start_period;
                mode_next   = bssc_pkg::MODE_OPEN;
            end
            default:
            begin
                did = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result.step       = step_next;
        result.drive      = bssc_pkg::drive_lookup(step_next, mode_next);
        result.period     = period_next;
        result.mode       = mode_next;
        result.commutated = did;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 3'd0;
            mode_reg   <= bssc_pkg::MODE_STOPPED;
            period_reg <= bssc_pkg::PERIOD_RST;
            agree_reg  <= 16'sd0;
        end
        else if (fire)
        begin
            step_reg   <= step_next;
            mode_reg   <= mode_next;
            period_reg <= period_next;
            agree_reg  <= agree_next;
        end
    end

    `BSSC_ASSERT_IMPLY(a_step_range, clk, rst_n, 1'b1, step_reg <= bssc_pkg::STEP_LAST,
        "step out of range")
    `BSSC_ASSERT_IMPLY(a_did_moves_step, clk, rst_n, fire && did, step_next != step_reg,
        "commutation without step change")
    `BSSC_ASSERT_NEXT(a_no_restop, clk, rst_n, mode_reg != bssc_pkg::MODE_STOPPED,
        mode_reg != bssc_pkg::MODE_STOPPED, "mode fell back to stopped")
    `BSSC_ASSERT_NEXT(a_hold_idle, clk, rst_n, !fire,
        $stable(period_reg) && $stable(step_reg) && $stable(agree_reg),
        "state changed without an item")

endmodule

>>> rtl/bldc_six_step_sensorless_commutator_top.sv
// Top level of the six-step sensorless BLDC commutator
//
// Channels: items enter on in_valid/in_stall with opcode (tick, sample, start)
// and three phase voltage codes; one result leaves per item on
// out_valid/out_stall carrying step, phase drives, timer period, mode and a
// commutation flag. Registers are written on cfg_valid/cfg_ready (always
// ready) with cfg_index selecting start_period, ramp_step, min_period,
// crossing_limit or reverse_direction.
// An accepted beat waits in the input register; its result is then captured
// in the result register for out_valid. Throughput: one item per cycle while
// out_stall is low, through a single stage of compare and counter logic.
// Stall: while out_stall holds a pending result, the item in the input
// register waits and in_stall rises; a new beat is still taken whenever the
// input register moves on in the same cycle.
// Reset: mode stopped, step 0, period 10000, agreement count 0, registers at
// their defaults, both pipeline registers empty.
module bldc_six_step_sensorless_commutator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [bssc_pkg::ADC_BITS-1:0] volt_a,
    input  logic [bssc_pkg::ADC_BITS-1:0] volt_b,
    input  logic [bssc_pkg::ADC_BITS-1:0] volt_c,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    step_now,
    output logic [1:0]                    drive_a,
    output logic [1:0]                    drive_b,
    output logic [1:0]                    drive_c,
    output logic [15:0]                   timer_period,
    output logic [1:0]                    mode_now,
    output logic                          commutated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bssc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    bssc_pkg::cfg_t    cfg;
    bssc_pkg::item_t   item_reg;
    bssc_pkg::item_t   item_next;
    logic              item_valid_reg;
    logic              item_valid_next;
    bssc_pkg::result_t result;
    bssc_pkg::result_t result_reg;
    bssc_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              fire;
    logic              accept;

    bssc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bssc_commutate u_comm (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_next       = '{opcode: opcode, volt_a: volt_a, volt_b: volt_b, volt_c: volt_c};
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            result_next    = result;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign step_now     = result_reg.step;
    assign drive_a      = result_reg.drive.a;
    assign drive_b      = result_reg.drive.b;
    assign drive_c      = result_reg.drive.c;
    assign timer_period = result_reg.period;
    assign mode_now     = result_reg.mode;
    assign commutated   = result_reg.commutated;

endmodule

>>> tb/bldc_six_step_sensorless_commutator_top_tb.sv
// Testbench for the six-step sensorless commutator: directed and random beats, scoreboard checks
`timescale 1ns / 100ps

module bldc_six_step_sensorless_commutator_top_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [bssc_pkg::CFG_IDX_W-1:0] REG_NONE_FIRST = 3'd5;
    localparam logic [bssc_pkg::CFG_IDX_W-1:0] REG_NONE_LAST  = 3'd7;

    class commutator_scoreboard;
        bssc_pkg::cfg_t      regs;
        logic [2:0]          step;
        bssc_pkg::mode_t     mode;
        logic [15:0]         period;
        logic signed [15:0]  agree_cnt;
        bssc_pkg::result_t   expected_q[$];
        int                  errors;

        function new();
            regs.start_period      = bssc_pkg::START_PERIOD_RST;
            regs.ramp_step         = bssc_pkg::RAMP_STEP_RST;
            regs.min_period        = bssc_pkg::MIN_PERIOD_RST;
            regs.crossing_limit    = bssc_pkg::CROSS_LIMIT_RST;
            regs.reverse_direction = 1'b0;
            step      = 3'd0;
            mode      = bssc_pkg::MODE_STOPPED;
            period    = bssc_pkg::PERIOD_RST;
            agree_cnt = 16'sd0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [bssc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                bssc_pkg::REG_START_PERIOD: regs.start_period      = data;
                bssc_pkg::REG_RAMP_STEP:    regs.ramp_step         = data;
                bssc_pkg::REG_MIN_PERIOD:   regs.min_period        = data;
                bssc_pkg::REG_CROSS_LIMIT:  regs.crossing_limit    = data[7:0];
                bssc_pkg::REG_REVERSE:      regs.reverse_direction = data[0];
                default: ;
            endcase
        endfunction

        function void advance();
            if (regs.reverse_direction)
                step = (step == 3'd0 || step > bssc_pkg::STEP_LAST) ?
                       bssc_pkg::STEP_LAST : step - 3'd1;
            else
                step = (step >= bssc_pkg::STEP_LAST) ? 3'd0 : step + 3'd1;
        endfunction

        function bit floating_agrees(logic [9:0] va, logic [9:0] vb, logic [9:0] vc);
            int s;
            s = int'(va) + int'(vb) + int'(vc);
            case (step)
                3'd0: return 3 * int'(vc) < s;
                3'd1: return 3 * int'(vb) > s;
                3'd2: return 3 * int'(va) < s;
                3'd3: return 3 * int'(vc) > s;
                3'd4: return 3 * int'(vb) < s;
                3'd5: return 3 * int'(va) > s;
                default: return 1'b0;
            endcase
        endfunction

        function bssc_pkg::drive_set_t phase_drives();
            bssc_pkg::drive_set_t d;
            d.a = bssc_pkg::DRV_OFF;
            d.b = bssc_pkg::DRV_OFF;
            d.c = bssc_pkg::DRV_OFF;
            if (mode != bssc_pkg::MODE_STOPPED)
            begin
                case (step)
                    3'd0: begin d.a = bssc_pkg::DRV_HIGH; d.b = bssc_pkg::DRV_LOW;  end
                    3'd1: begin d.a = bssc_pkg::DRV_HIGH; d.c = bssc_pkg::DRV_LOW;  end
                    3'd2: begin d.b = bssc_pkg::DRV_HIGH; d.c = bssc_pkg::DRV_LOW;  end
                    3'd3: begin d.a = bssc_pkg::DRV_LOW;  d.b = bssc_pkg::DRV_HIGH; end
                    3'd4: begin d.a = bssc_pkg::DRV_LOW;  d.c = bssc_pkg::DRV_HIGH; end
                    3'd5: begin d.b = bssc_pkg::DRV_LOW;  d.c = bssc_pkg::DRV_HIGH; end
                    default: ;
                endcase
            end
            return d;
        endfunction

        function void note_item(logic [1:0] op, logic [9:0] va, logic [9:0] vb, logic [9:0] vc);
            bssc_pkg::result_t r;
            bit                did;
            did = 1'b0;
            case (op)
                bssc_pkg::OP_TICK:
                begin
                    if (mode == bssc_pkg::MODE_OPEN)
                    begin
                        if (period > regs.min_period)
                            period = (period > regs.ramp_step) ? period - regs.ramp_step : 16'd0;
                        else
                            mode = bssc_pkg::MODE_TRANS;
                        advance();
                        did = 1'b1;
                    end
                    else if (mode == bssc_pkg::MODE_TRANS)
                    begin
                        advance();
                        did = 1'b1;
                    end
                end
                bssc_pkg::OP_SAMPLE:
                begin
                    if (mode == bssc_pkg::MODE_TRANS || mode == bssc_pkg::MODE_CLOSED)
                    begin
                        if (floating_agrees(va, vb, vc))
                        begin
                            if (agree_cnt != bssc_pkg::CNT_MAX)
                                agree_cnt = agree_cnt + 16'sd1;
                        end
                        else if (agree_cnt != bssc_pkg::CNT_MIN)
                            agree_cnt = agree_cnt - 16'sd1;
                        if (int'(agree_cnt) > int'(regs.crossing_limit))
                        begin
                            agree_cnt = 16'sd0;
                            mode      = bssc_pkg::MODE_CLOSED;
                            advance();
                            did = 1'b1;
                        end
                    end
                end
                bssc_pkg::OP_START:
                begin
                    period = regs.start_period;
                    mode   = bssc_pkg::MODE_OPEN;
                end
                default: ;
            endcase
            r.step       = step;
            r.drive      = phase_drives();
            r.period     = period;
            r.mode       = mode;
            r.commutated = did;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            end
        endfunction

        function void check_result(bssc_pkg::result_t got);
            bssc_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: unexpected result, expected none, actual step %0d mode %0d",
                             $time, got.step, got.mode);
                return;
            end
            want = expected_q.pop_front();
            compare_field("step_now", 16'(want.step), 16'(got.step));
            compare_field("drive_a", 16'(want.drive.a), 16'(got.drive.a));
            compare_field("drive_b", 16'(want.drive.b), 16'(got.drive.b));
            compare_field("drive_c", 16'(want.drive.c), 16'(got.drive.c));
            compare_field("timer_period", want.period, got.period);
            compare_field("mode_now", 16'(want.mode), 16'(got.mode));
            compare_field("commutated", 16'(want.commutated), 16'(got.commutated));
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [1:0]                     opcode    = bssc_pkg::OP_TICK;
    logic [bssc_pkg::ADC_BITS-1:0]  volt_a    = '0;
    logic [bssc_pkg::ADC_BITS-1:0]  volt_b    = '0;
    logic [bssc_pkg::ADC_BITS-1:0]  volt_c    = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [bssc_pkg::CFG_IDX_W-1:0] cfg_index = bssc_pkg::REG_START_PERIOD;
    logic [15:0]                    cfg_data  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic [2:0]           step_now;
    logic [1:0]           drive_a;
    logic [1:0]           drive_b;
    logic [1:0]           drive_c;
    logic [15:0]          timer_period;
    logic [1:0]           mode_now;
    logic                 commutated;
    logic                 cfg_ready;

    commutator_scoreboard sb = new();

    int beats_sent = 0;
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;

    bldc_six_step_sensorless_commutator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .volt_a       (volt_a),
        .volt_b       (volt_b),
        .volt_c       (volt_c),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .step_now     (step_now),
        .drive_a      (drive_a),
        .drive_b      (drive_b),
        .drive_c      (drive_c),
        .timer_period (timer_period),
        .mode_now     (mode_now),
        .commutated   (commutated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // hold off the receiver on request, else stall at random unless calm
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 200;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (calm)
            out_stall = 1'b0;
        else
            out_stall = ($urandom_range(0, 99) < 28);
    end

    always @(posedge clk)
    begin
        bssc_pkg::result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.step       = step_now;
            got.drive.a    = drive_a;
            got.drive.b    = drive_b;
            got.drive.c    = drive_c;
            got.period     = timer_period;
            got.mode       = bssc_pkg::mode_t'(mode_now);
            got.commutated = commutated;
            sb.check_result(got);
        end
    end

    task automatic send_item(logic [1:0] op, logic [9:0] va, logic [9:0] vb, logic [9:0] vc);
        if (!calm && $urandom_range(0, 99) < 28)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        opcode   = op;
        volt_a   = va;
        volt_b   = vb;
        volt_c   = vc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(op, va, vb, vc);
        beats_sent++;
    endtask

    task automatic send_noise(logic [1:0] op);
        send_item(op, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)));
    endtask

    // when agree is set, bias the floating phase to the side that counts as a crossing
    task automatic send_sample(bit agree);
        logic [9:0] v[3];
        int         fl;
        bit         up;
        fl = 0;
        up = 1'b0;
        for (int i = 0; i < 3; i++)
            v[i] = 10'($urandom_range(0, 1023));
        if (agree && sb.step <= bssc_pkg::STEP_LAST)
        begin
            case (sb.step)
                3'd0: begin fl = 2; up = 1'b0; end
                3'd1: begin fl = 1; up = 1'b1; end
                3'd2: begin fl = 0; up = 1'b0; end
                3'd3: begin fl = 2; up = 1'b1; end
                3'd4: begin fl = 1; up = 1'b0; end
                default: begin fl = 0; up = 1'b1; end
            endcase
            for (int i = 0; i < 3; i++)
                v[i] = up ? 10'($urandom_range(0, 650)) : 10'($urandom_range(350, 1023));
            v[fl] = up ? 10'($urandom_range(700, 1023)) : 10'($urandom_range(0, 300));
        end
        send_item(bssc_pkg::OP_SAMPLE, v[0], v[1], v[2]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [bssc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] sp, logic [15:0] rs, logic [15:0] mp,
                            logic [15:0] cl, logic [15:0] rv);
        write_reg(bssc_pkg::REG_START_PERIOD, sp);
        write_reg(bssc_pkg::REG_RAMP_STEP, rs);
        write_reg(bssc_pkg::REG_MIN_PERIOD, mp);
        write_reg(bssc_pkg::REG_CROSS_LIMIT, cl);
        write_reg(bssc_pkg::REG_REVERSE, rv);
    endtask

    task automatic run_phase(int target, bit do_hold, bit do_pause, bit do_calm);
        int first;
        int n;
        int k;
        bit held;
        bit paused;
        first  = beats_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (beats_sent - first < target)
        begin
            if (do_hold && !held && beats_sent - first >= target / 3)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (do_pause && !paused && beats_sent - first >= target / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if (do_calm)
                calm = (beats_sent - first >= target / 4) && (beats_sent - first < 3 * target / 4);
            if ($urandom_range(0, 99) < 85)
            begin
                send_noise(bssc_pkg::OP_START);
                n = 0;
                while (sb.mode == bssc_pkg::MODE_OPEN && n < 40)
                begin
                    send_noise(bssc_pkg::OP_TICK);
                    n++;
                end
                repeat ($urandom_range(0, 3)) send_noise(bssc_pkg::OP_TICK);
                repeat ($urandom_range(5, 60))
                begin
                    k = $urandom_range(0, 99);
                    if (k < 8)
                        send_noise(bssc_pkg::OP_TICK);
                    else if (k < 11)
                        send_noise(OP_UNUSED);
                    else
                        send_sample(k < 80);
                end
            end
            else
                send_noise(2'($urandom_range(0, 3)));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [9:0]  v;
        logic [15:0] sp;
        logic [15:0] rs;
        logic [15:0] mp;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, ignored items while stopped
        send_item(bssc_pkg::OP_TICK, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
        send_item(OP_UNUSED, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_START, 10'd1023, 10'd0, 10'd1023);
        send_item(bssc_pkg::OP_TICK, 10'd0, 10'd1023, 10'd0);
        send_item(bssc_pkg::OP_TICK, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_SAMPLE, 10'd1023, 10'd0, 10'd0);
        wait_drained();

        // directed: ramp underflow, reverse wrap, commutation at zero limit
        set_regs(16'd100, 16'hFFFF, 16'd0, 16'hFF00, 16'hFFFF);
        write_reg(REG_NONE_LAST, 16'hFFFF);
        send_item(bssc_pkg::OP_START, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_TICK, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_TICK, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_TICK, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_SAMPLE, 10'd1023, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_SAMPLE, 10'd0, 10'd0, 10'd0);
        send_item(bssc_pkg::OP_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b1);
        send_item(bssc_pkg::OP_TICK, 10'd1023, 10'd1023, 10'd1023);
        send_item(OP_UNUSED, 10'd1023, 10'd1023, 10'd1023);
        send_item(bssc_pkg::OP_START, 10'd0, 10'd0, 10'd0);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
                1: set_regs(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_regs(16'd3000, 16'd0, 16'd100, 16'd3, 16'd0);
                default:
                begin
                    sp = 16'($urandom_range(0, 3000));
                    rs = 16'($urandom_range(1, 500));
                    mp = 16'($urandom_range(0, 1500));
                    set_regs(sp, rs, mp, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 20))},
                             {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))});
                    write_reg(3'($urandom_range(REG_NONE_FIRST, REG_NONE_LAST)),
                              16'($urandom_range(0, 65535)));
                end
            endcase
            run_phase(115, p == 4, p == 5, p == 6);
            wait_drained();
        end

        // drive the agreement count negative, then climb back past the limit
        set_regs(16'd0, 16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(0, 1)));
        send_noise(bssc_pkg::OP_START);
        send_noise(bssc_pkg::OP_TICK);
        calm = 1'b1;
        repeat (60)
        begin
            v = 10'($urandom_range(0, 1023));
            send_item(bssc_pkg::OP_SAMPLE, v, v, v);
        end
        repeat (330) send_sample(1'b1);
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
